// ===== rtl/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg: shared definitions for the Laplacian sharpness measure
// Field widths, register map, kernel weights and controller interface types.
// ----------------------------------------------------------------------------
package lsm_pkg;

  // default sizing
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_FRAC_BITS  = 8;

  // field widths
  localparam int PIX_W  = 8;
  localparam int REG_W  = 13;
  localparam int SUM_W  = 37;
  localparam int MEAN_W = 21;
  localparam int LAP_W  = 13;  // |response| <= 5100
  localparam int SAC_W  = 14;  // weighted tap sums <= 5100

  // kernel weights
  localparam int KERNEL_EDGE   = 4;
  localparam int KERNEL_CENTER = 20;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [REG_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [REG_W-1:0] RESET_HEIGHT = 13'd480;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,
    S_ADD,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
    logic             restart;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic proc;
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/lsm_ram.sv =====
// ----------------------------------------------------------------------------
// lsm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lsm_regs.sv =====
// ----------------------------------------------------------------------------
// lsm_regs: APB configuration registers
// Holds frame width and height; any write restarts the frame.
// ----------------------------------------------------------------------------
module lsm_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lsm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lsm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output lsm_pkg::cfg_t                    cfg
);

  logic [lsm_pkg::REG_W-1:0] image_width;
  logic [lsm_pkg::REG_W-1:0] image_height;
  logic                      wr_en;
  logic                      reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lsm_pkg::RESET_WIDTH;
      image_height <= lsm_pkg::RESET_HEIGHT;
    end else if (wr_en) begin
      if (reg_index == lsm_pkg::REG_IMAGE_WIDTH) begin
        image_width <= pwdata[lsm_pkg::REG_W-1:0];
      end else begin
        image_height <= pwdata[lsm_pkg::REG_W-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (reg_index == lsm_pkg::REG_IMAGE_HEIGHT) begin
      prdata = lsm_pkg::APB_DATA_W'(image_height);
    end else begin
      prdata = lsm_pkg::APB_DATA_W'(image_width);
    end
  end

  assign cfg.width   = image_width;
  assign cfg.height  = image_height;
  assign cfg.restart = wr_en;

endmodule

// ===== rtl/lsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsm_ctrl: sequencing controller
// Steps each pixel through accept and filter, then runs the end-of-frame
// accumulate, divider load, divide iterations and result hand-off.
// ----------------------------------------------------------------------------
module lsm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  lsm_pkg::status_t status,
  output lsm_pkg::cmd_t    cmd
);

  lsm_pkg::state_t state;
  lsm_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    pixel_ready = 1'b0;
    case (state)
      lsm_pkg::S_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.accept = 1'b1;
          state_next = lsm_pkg::S_PROC;
        end
      end
      lsm_pkg::S_PROC: begin
        cmd.proc = 1'b1;
        state_next = status.frame_end ? lsm_pkg::S_ADD : lsm_pkg::S_IDLE;
      end
      // bubble: last response lands in the running sum
      lsm_pkg::S_ADD: begin
        state_next = lsm_pkg::S_LOAD;
      end
      lsm_pkg::S_LOAD: begin
        cmd.load = 1'b1;
        state_next = lsm_pkg::S_DIV;
      end
      lsm_pkg::S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = lsm_pkg::S_DONE;
        end
      end
      lsm_pkg::S_DONE: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          state_next = lsm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lsm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lsm_datapath.sv =====
// ----------------------------------------------------------------------------
// lsm_datapath: filter, accumulator and divider datapath
// Two line stores and a 3x2 window feed the 3x3 Laplacian; absolute
// responses accumulate, and a restoring divider forms the Q mean.
// ----------------------------------------------------------------------------
module lsm_datapath #(
  parameter int MAX_WIDTH  = lsm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lsm_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = lsm_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lsm_pkg::cfg_t                 cfg,
  input  lsm_pkg::cmd_t                 cmd,
  output lsm_pkg::status_t              status,
  input  logic [lsm_pkg::PIX_W-1:0]     pixel,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [lsm_pkg::SUM_W-1:0]     abs_sum,
  output logic [lsm_pkg::MEAN_W-1:0]    mean_q8
);

  localparam int REG_W = lsm_pkg::REG_W;
  localparam int SAC_W = lsm_pkg::SAC_W;
  localparam int LAP_W = lsm_pkg::LAP_W;
  localparam int SUM_W = lsm_pkg::SUM_W;
  localparam int PIX_W = lsm_pkg::PIX_W;
  localparam int EW  = ($clog2(MAX_WIDTH + 1) > REG_W) ? $clog2(MAX_WIDTH + 1) : REG_W;
  localparam int EH  = ($clog2(MAX_HEIGHT + 1) > REG_W) ? $clog2(MAX_HEIGHT + 1) : REG_W;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int DW  = EW + EH;
  localparam int NW  = SUM_W + FRAC_BITS;
  localparam int DCW = $clog2(NW);

  // effective frame size
  logic [EW-1:0] w_raw, w_eff;
  logic [EH-1:0] h_raw, h_eff;
  logic [DW-1:0] count_reg;
  logic          small_reg;

  assign w_raw = EW'(cfg.width);
  assign h_raw = EH'(cfg.height);

  always_comb begin
    if (w_raw == '0) begin
      w_eff = EW'(1);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = EH'(1);
    end else if (h_raw > EH'(MAX_HEIGHT)) begin
      h_eff = EH'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // interior count, settled long before the frame ends
  always_ff @(posedge clk) begin
    small_reg <= (w_eff < EW'(3)) || (h_eff < EH'(3));
    count_reg <= DW'(w_eff - EW'(2)) * DW'(h_eff - EH'(2));
  end

  // frame position
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          last_col, last_row, interior;

  assign last_col = (EW'(col) + EW'(1)) >= w_eff;
  assign last_row = (EH'(row) + EH'(1)) >= h_eff;
  assign interior = (col >= CW'(2)) && (row >= RW'(2));
  assign status.frame_end = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col <= '0;
      row <= '0;
    end else if (cmd.proc) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // line stores: a holds previous line, b the one before it
  logic [PIX_W-1:0] pix_reg;
  logic [PIX_W-1:0] top, mid;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_reg <= pixel;
    end
  end

  lsm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (cmd.proc),
    .waddr (col),
    .wdata (pix_reg),
    .raddr (col),
    .rdata (mid)
  );

  lsm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (cmd.proc),
    .waddr (col),
    .wdata (mid),
    .raddr (col),
    .rdata (top)
  );

  // window: [0..2] column c-2, [3..5] column c-1 (top, mid, bottom)
  logic [PIX_W-1:0] win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (cmd.proc) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= pix_reg;
    end
  end

  // kernel response magnitude
  logic [SAC_W-1:0] corner_sum, edge_sum, pos_sum, neg_sum;
  logic [LAP_W-1:0] lap_abs;

  always_comb begin
    corner_sum = SAC_W'(win[0]) + SAC_W'(win[2]) + SAC_W'(top) + SAC_W'(pix_reg);
    edge_sum   = SAC_W'(win[1]) + SAC_W'(win[3]) + SAC_W'(mid) + SAC_W'(win[5]);
    pos_sum    = corner_sum + SAC_W'(lsm_pkg::KERNEL_EDGE) * edge_sum;
    neg_sum    = SAC_W'(lsm_pkg::KERNEL_CENTER) * SAC_W'(win[4]);
    if (pos_sum >= neg_sum) begin
      lap_abs = LAP_W'(pos_sum - neg_sum);
    end else begin
      lap_abs = LAP_W'(neg_sum - pos_sum);
    end
  end

  // response register, added to the sum in the following cycle
  logic [LAP_W-1:0] lap_reg;
  logic             lap_pend;
  logic [SUM_W-1:0] run_sum;

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      lap_pend <= 1'b0;
    end else begin
      lap_pend <= cmd.proc && interior;
    end
    lap_reg <= lap_abs;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart || cmd.load) begin
      run_sum <= '0;
    end else if (lap_pend) begin
      run_sum <= run_sum + SUM_W'(lap_reg);
    end
  end

  // restoring divider, one quotient bit per step
  logic [NW-1:0]  quo;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  den;
  logic [DCW-1:0] div_cnt;
  logic [SUM_W-1:0] sum_hold;
  logic           small_hold;
  logic [DW:0]    rem_sh;
  logic           rem_ge;

  assign rem_sh = {rem, quo[NW-1]};
  assign rem_ge = rem_sh >= {1'b0, den};
  assign status.div_last = div_cnt == DCW'(NW - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo        <= NW'(run_sum) << FRAC_BITS;
      rem        <= '0;
      den        <= small_reg ? DW'(1) : count_reg;
      div_cnt    <= '0;
      sum_hold   <= run_sum;
      small_hold <= small_reg;
    end else if (cmd.step) begin
      quo     <= {quo[NW-2:0], rem_ge};
      rem     <= rem_ge ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
      div_cnt <= div_cnt + DCW'(1);
    end
  end

  // result register
  assign status.out_busy = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      abs_sum <= small_hold ? '0 : sum_hold;
      mean_q8 <= small_hold ? '0 : quo[lsm_pkg::MEAN_W-1:0];
    end
  end

endmodule

// ===== rtl/laplacian_sharpness_measure.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpness_measure: 3x3 mean absolute Laplacian focus measure
// Raster luma in, one sum and Q mean out at the end of each frame.
// ----------------------------------------------------------------------------
// Each pixel takes an accept step and then a filter step, and the next pixel
// is not taken until the filter step is done, since the line stores are
// one-write, one-read RAMs with a registered read at the current column.
// After the last pixel of a frame the block accumulates, loads and runs the
// bit-serial divider and hands off the result, and accepts no pixel
// meanwhile; the hand-off waits while an earlier result is still held in the
// output register. The result then sits in that register so the next frame
// can start before it is taken. Line stores need no clearing after reset.
// Writing either size register restarts the frame; sizes of 0 act as 1 and
// sizes above the maximum saturate. Frames below 3x3 report zeros.
// ----------------------------------------------------------------------------
module laplacian_sharpness_measure #(
  parameter int MAX_WIDTH  = lsm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lsm_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = lsm_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lsm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lsm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  logic [lsm_pkg::PIX_W-1:0]       pixel,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [lsm_pkg::SUM_W-1:0]       abs_sum,
  output logic [lsm_pkg::MEAN_W-1:0]      mean_q8
);

  lsm_pkg::cfg_t    cfg;
  lsm_pkg::cmd_t    cmd;
  lsm_pkg::status_t status;

  lsm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .status      (status),
    .cmd         (cmd)
  );

  lsm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .abs_sum      (abs_sum),
    .mean_q8      (mean_q8)
  );

endmodule

// ===== bench/laplacian_sharpness_measure_tb.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpness_measure_tb: self-checking bench for the focus measure
// Streams raster luma frames through the block and compares each end-of-frame
// sum and Q8 mean against a cycle-free predictor of the 3x3 Laplacian.
// Frame sizes are set over APB between frames or to cut one short, and read
// back. The run covers degenerate sizes, saturated widths and heights, and
// random frames. Both handshakes see random idle bursts.
// ----------------------------------------------------------------------------
module laplacian_sharpness_measure_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lsm_pkg::APB_ADDR_W-1:0] WIDTH_ADDR  =
    {lsm_pkg::REG_IMAGE_WIDTH, 2'b00};
  localparam logic [lsm_pkg::APB_ADDR_W-1:0] HEIGHT_ADDR =
    {lsm_pkg::REG_IMAGE_HEIGHT, 2'b00};
  // end-of-frame accumulate and divide, plus margin
  localparam int DRAIN_CYCLES = 3 + lsm_pkg::SUM_W + lsm_pkg::DEF_FRAC_BITS + 16;
  localparam int RANDOM_PIXELS = 560;
  localparam logic [lsm_pkg::SUM_W-1:0]  PEAK_SUM  = 37'd5100;
  localparam logic [lsm_pkg::MEAN_W-1:0] PEAK_MEAN = 21'd1305600;

  typedef enum int {PAT_NOISE, PAT_BINARY, PAT_RAMP, PAT_FLAT} pattern_t;

  typedef struct packed {
    logic [lsm_pkg::SUM_W-1:0]  sum;
    logic [lsm_pkg::MEAN_W-1:0] mean;
  } focus_t;

  typedef struct packed {
    bit                         resize;
    logic [lsm_pkg::REG_W-1:0]  w;
    logic [lsm_pkg::REG_W-1:0]  h;
    logic [lsm_pkg::PIX_W-1:0]  pix;
    bit                         known;
    logic [lsm_pkg::SUM_W-1:0]  sum;
    logic [lsm_pkg::MEAN_W-1:0] mean;
  } directed_row_t;

  // DUT ports
  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [lsm_pkg::APB_ADDR_W-1:0] paddr;
  logic [lsm_pkg::APB_DATA_W-1:0] pwdata;
  logic [lsm_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           pixel_valid;
  logic                           pixel_ready;
  logic [lsm_pkg::PIX_W-1:0]      pixel;
  logic                           result_valid;
  logic                           result_ready;
  logic [lsm_pkg::SUM_W-1:0]      abs_sum;
  logic [lsm_pkg::MEAN_W-1:0]     mean_q8;

  // predictor state
  logic [lsm_pkg::REG_W-1:0] width_reg;
  logic [lsm_pkg::REG_W-1:0] height_reg;
  logic [lsm_pkg::PIX_W-1:0] line_prev [lsm_pkg::DEF_MAX_WIDTH];
  logic [lsm_pkg::PIX_W-1:0] line_older [lsm_pkg::DEF_MAX_WIDTH];
  logic [lsm_pkg::PIX_W-1:0] taps [6];
  int unsigned               col_pos;
  int unsigned               row_pos;
  logic [lsm_pkg::SUM_W-1:0] lap_acc;

  focus_t      expected_measures [$];
  int unsigned mismatch_count = 0;
  int unsigned pixel_count = 0;
  int unsigned idle_odds = 0;
  bit          calm = 1'b0;

  // directed frames: ring/center extremes at 3x3, then degenerate sizes
  directed_row_t directed_rows [24] = '{
    '{1'b1, 13'd3, 13'd3, 8'hFF, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h00, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b1, PEAK_SUM, PEAK_MEAN},
    '{1'b0, 13'd0, 13'd0, 8'h00, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h00, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h00, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h00, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h00, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h00, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h00, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h00, 1'b1, PEAK_SUM, PEAK_MEAN},
    '{1'b1, 13'd0, 13'd0, 8'hAA, 1'b1, 37'd0, 21'd0},
    '{1'b1, 13'd2, 13'd1, 8'h55, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b1, 37'd0, 21'd0},
    '{1'b1, 13'd1, 13'd3, 8'h00, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h80, 1'b0, 37'd0, 21'd0},
    '{1'b0, 13'd0, 13'd0, 8'h01, 1'b1, 37'd0, 21'd0}
  };

  laplacian_sharpness_measure u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .abs_sum      (abs_sum),
    .mean_q8      (mean_q8)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // size register as seen by the datapath: 0 acts as 1, saturates at the max
  function automatic int unsigned clamp_size(input logic [lsm_pkg::REG_W-1:0] r,
                                             input int unsigned lim);
    if (r == '0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  task automatic restart_frame();
    col_pos = 0;
    row_pos = 0;
    lap_acc = '0;
  endtask

  // one pixel through the predictor; emit set at the last pixel of a frame
  task automatic predict_focus(input logic [lsm_pkg::PIX_W-1:0] bot, output bit emit,
                               output focus_t res);
    int unsigned w, h, c, r;
    logic [lsm_pkg::PIX_W-1:0] top, mid;
    int resp;
    longint unsigned cnt, scaled;
    w = clamp_size(width_reg, lsm_pkg::DEF_MAX_WIDTH);
    h = clamp_size(height_reg, lsm_pkg::DEF_MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    top = line_older[c];
    mid = line_prev[c];
    emit = 1'b0;
    res = '0;

    // kernel response at the center of the window, interior only
    if (c >= 2 && r >= 2) begin
      resp = int'(taps[0]) + lsm_pkg::KERNEL_EDGE * int'(taps[3]) + int'(top)
           + lsm_pkg::KERNEL_EDGE * int'(taps[1])
           - lsm_pkg::KERNEL_CENTER * int'(taps[4])
           + lsm_pkg::KERNEL_EDGE * int'(mid)
           + int'(taps[2]) + lsm_pkg::KERNEL_EDGE * int'(taps[5]) + int'(bot);
      if (resp < 0) resp = -resp;
      lap_acc = lap_acc + lsm_pkg::SUM_W'(resp);
    end

    // slide window, update line stores
    taps[0] = taps[3];
    taps[1] = taps[4];
    taps[2] = taps[5];
    taps[3] = top;
    taps[4] = mid;
    taps[5] = bot;
    line_older[c] = mid;
    line_prev[c] = bot;

    if (c + 1 >= w && r + 1 >= h) begin
      emit = 1'b1;
      if (w >= 3 && h >= 3) begin
        cnt = longint'(w - 2) * longint'(h - 2);
        scaled = longint'(lap_acc) << lsm_pkg::DEF_FRAC_BITS;
        res.sum = lap_acc;
        res.mean = lsm_pkg::MEAN_W'(scaled / cnt);
      end
      restart_frame();
    end else if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic apb_write(input logic [lsm_pkg::APB_ADDR_W-1:0] addr,
                           input logic [lsm_pkg::APB_DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // read a size register back and compare with the predictor's copy
  task automatic check_reg(input logic [lsm_pkg::APB_ADDR_W-1:0] addr,
                           input logic [lsm_pkg::REG_W-1:0] want);
    logic [lsm_pkg::APB_DATA_W-1:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[lsm_pkg::REG_W-1:0] !== want) begin
      $display("%0t: register at 0x%0h mismatch, expected %0d, actual %0d",
               $time, addr, want, got[lsm_pkg::REG_W-1:0]);
      mismatch_count++;
    end
  endtask

  // wait for the block to go idle, then rewrite one or both sizes
  task automatic write_sizes(input bit do_w, input logic [lsm_pkg::REG_W-1:0] w,
                             input bit do_h, input logic [lsm_pkg::REG_W-1:0] h);
    logic [lsm_pkg::APB_DATA_W-1:0] data;
    pixel_valid <= 1'b0;
    while (expected_measures.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (do_w) begin
      data = $urandom;
      data[lsm_pkg::REG_W-1:0] = w;
      apb_write(WIDTH_ADDR, data);
      width_reg = w;
      restart_frame();
    end
    if (do_h) begin
      data = $urandom;
      data[lsm_pkg::REG_W-1:0] = h;
      apb_write(HEIGHT_ADDR, data);
      height_reg = h;
      restart_frame();
    end
    check_reg(WIDTH_ADDR, width_reg);
    check_reg(HEIGHT_ADDR, height_reg);
  endtask

  // one pixel transaction; a known result overrides the predicted one
  task automatic send_pixel(input logic [lsm_pkg::PIX_W-1:0] value, input bit known,
                            input focus_t known_res);
    int unsigned gap;
    bit emit;
    focus_t res;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 7);
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= value;
    do @(posedge clk); while (!pixel_ready);
    predict_focus(value, emit, res);
    if (emit) expected_measures.push_back(known ? known_res : res);
    pixel_count++;
  endtask

  // one whole frame at the current size, or only its first max_pixels pixels
  task automatic run_frame(input pattern_t pat, input int unsigned max_pixels = 0);
    int unsigned w, n;
    logic [lsm_pkg::PIX_W-1:0] base, v;
    w = clamp_size(width_reg, lsm_pkg::DEF_MAX_WIDTH);
    n = w * clamp_size(height_reg, lsm_pkg::DEF_MAX_HEIGHT);
    if (max_pixels != 0 && max_pixels < n) n = max_pixels;
    base = lsm_pkg::PIX_W'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      case (pat)
        PAT_NOISE:  v = lsm_pkg::PIX_W'($urandom);
        PAT_BINARY: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PAT_RAMP:   v = base + lsm_pkg::PIX_W'((i % w) * 3)
                        + lsm_pkg::PIX_W'($urandom_range(0, 3));
        default:    v = base;
      endcase
      send_pixel(v, 1'b0, '0);
    end
  endtask

  // stimulus
  initial begin
    focus_t known_res;
    logic [lsm_pkg::REG_W-1:0] w, h;
    int unsigned mask;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pixel_valid = 1'b0;
    pixel = '0;

    width_reg = 13'd640;
    height_reg = 13'd480;
    foreach (taps[k]) taps[k] = '0;
    restart_frame();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    check_reg(WIDTH_ADDR, width_reg);
    check_reg(HEIGHT_ADDR, height_reg);

    // directed table
    idle_odds = 3;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].resize)
        write_sizes(1'b1, directed_rows[k].w, 1'b1, directed_rows[k].h);
      known_res.sum = directed_rows[k].sum;
      known_res.mean = directed_rows[k].mean;
      send_pixel(directed_rows[k].pix, directed_rows[k].known, known_res);
    end

    // random small frames
    while (pixel_count < RANDOM_PIXELS + $size(directed_rows)) begin
      if ($urandom_range(0, 9) < 7) begin
        w = ($urandom_range(0, 9) == 0) ? lsm_pkg::REG_W'($urandom_range(0, 2))
                                        : lsm_pkg::REG_W'($urandom_range(3, 14));
        h = ($urandom_range(0, 9) == 0) ? lsm_pkg::REG_W'($urandom_range(0, 2))
                                        : lsm_pkg::REG_W'($urandom_range(3, 8));
        mask = $urandom_range(1, 3);
        write_sizes(mask[0], w, mask[1], h);
      end
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 8;
        default: idle_odds = 2;
      endcase
      run_frame(pattern_t'($urandom_range(0, 3)));
    end

    // saturated sizes: start of the widest line, tallest frame, single column;
    // each is cut short by the restart of the next size write
    idle_odds = 6;
    write_sizes(1'b1, 13'd8191, 1'b1, 13'd3);
    run_frame(PAT_BINARY, 16);
    write_sizes(1'b1, 13'd3, 1'b1, 13'd4097);
    run_frame(PAT_NOISE, 24);
    write_sizes(1'b1, 13'd0, 1'b1, 13'd8191);
    run_frame(PAT_NOISE, 8);

    // closing stretch at full rate on both sides
    calm = 1'b1;
    idle_odds = 0;
    write_sizes(1'b1, 13'd5, 1'b1, 13'd4);
    run_frame(PAT_NOISE);
    run_frame(PAT_BINARY);
    write_sizes(1'b1, 13'd3, 1'b0, 13'd0);
    run_frame(PAT_RAMP);

    pixel_valid <= 1'b0;
    while (expected_measures.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side: random stalls, compare against the oldest expectation
  initial begin
    int unsigned hold;
    focus_t want;
    hold = 0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        if (expected_measures.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual sum %0d mean %0d",
                   $time, abs_sum, mean_q8);
          mismatch_count++;
        end else begin
          want = expected_measures.pop_front();
          if (abs_sum !== want.sum) begin
            $display("%0t: abs_sum mismatch, expected %0d, actual %0d",
                     $time, want.sum, abs_sum);
            mismatch_count++;
          end
          if (mean_q8 !== want.mean) begin
            $display("%0t: mean_q8 mismatch, expected %0d, actual %0d",
                     $time, want.mean, mean_q8);
            mismatch_count++;
          end
        end
      end
      if (hold != 0) begin
        hold--;
        result_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(0, 6);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
